>>> hw/rtl/mlw_pkg.sv
package mlw_pkg;

  localparam int SIZE_W = 14;
  localparam int NODE_W = 20;
  localparam int FRAC_W = 16;
  localparam int NORM_W = 29;
  localparam int OUT_W  = 24;
  localparam int IDX_W  = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_IN_WIDTH   = 2'd0,
    REG_IN_HEIGHT  = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    op_t         op;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [19:0] nx;
    logic [19:0] ny;
  } side_t;

  function automatic logic [OUT_W-1:0] sat24(input logic signed [28:0] v);
    logic [OUT_W-1:0] r;
    if (v > 29'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -29'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/mlw_ram.sv
module mlw_ram #(
  parameter int WIDTH  = 40,
  parameter int DEPTH  = 289,
  parameter int ADDR_W = 9
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/mlw_lerp.sv
module mlw_lerp (
  input  logic                              clk,
  input  logic                              en,
  input  logic [mlw_pkg::NODE_W-1:0]        a,
  input  logic [mlw_pkg::NODE_W-1:0]        b,
  input  logic [mlw_pkg::NODE_W-1:0]        c,
  input  logic [mlw_pkg::NODE_W-1:0]        d,
  input  logic [mlw_pkg::FRAC_W-1:0]        fu,
  input  logic [mlw_pkg::FRAC_W-1:0]        fv,
  output logic signed [mlw_pkg::NORM_W-1:0] n
);
  import mlw_pkg::*;

  logic signed [20:0] dab1, dcd1;
  logic signed [19:0] a1, c1;
  logic [15:0]        fu1, fv1, fv2, fv3;
  logic signed [37:0] pab, pcd;
  logic signed [37:0] top2, bot2, top3, top4;
  logic signed [38:0] dtb3;
  logic [35:0]        plo4;
  logic signed [35:0] phi4;
  logic signed [57:0] sum_c, sum5;

  assign pab = dab1 * $signed({1'b0, fu1});
  assign pcd = dcd1 * $signed({1'b0, fu1});
  assign sum_c = (58'(top4) <<< 16) + (58'(phi4) <<< 20) + $signed(58'(plo4));

  always_ff @(posedge clk) begin
    if (en) begin
      // cross differences, then blend along u
      dab1 <= $signed({b[19], b}) - $signed({a[19], a});
      dcd1 <= $signed({d[19], d}) - $signed({c[19], c});
      a1   <= $signed(a);
      c1   <= $signed(c);
      fu1  <= fu;
      fv1  <= fv;
      top2 <= $signed({{2{a1[19]}}, a1, 16'b0}) + pab;
      bot2 <= $signed({{2{c1[19]}}, c1, 16'b0}) + pcd;
      fv2  <= fv1;
      // blend along v, split product
      dtb3 <= $signed({bot2[37], bot2}) - $signed({top2[37], top2});
      top3 <= top2;
      fv3  <= fv2;
      plo4 <= dtb3[19:0] * fv3;
      phi4 <= $signed(dtb3[38:20]) * $signed({1'b0, fv3});
      top4 <= top3;
      sum5 <= sum_c;
      // round half up to q4.24
      n    <= NORM_W'((sum5 + 58'sd8388608) >>> 24);
    end
  end

endmodule

>>> hw/rtl/mesh_lut_warp_coordinate_mapper_top.sv
// Mesh warp coordinate mapper. Load beats (tuser 0) write one node of the
// GRID_W x GRID_H grid of normalized source coordinates; map beats (tuser 1)
// return one source coordinate pair in Q15.8 pixels, saturated. One beat is
// accepted every clock while the output is not stalled; the pipeline depth
// is set by the bit-serial divide by the output size, one quotient bit per
// stage. The grid lives in four RAM banks split by row and column parity so
// the four corners of a cell are read in the same cycle. A node must be
// loaded before a map beat reads it.
module mesh_lut_warp_coordinate_mapper_top #(
  parameter int GRID_W = 33,
  parameter int GRID_H = 33
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [mlw_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // node_col, node_row, node_src_x, node_src_y, pixel_u, pixel_v
  input  logic [79:0]                 s_axis_tdata,
  // operation
  input  logic [0:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // src_x, src_y
  output logic [47:0]                 m_axis_tdata
);
  import mlw_pkg::*;

  localparam int CB   = $clog2(GRID_W > GRID_H ? GRID_W : GRID_H);
  localparam int QB   = CB + FRAC_W;
  localparam int NW   = SIZE_W + CB;
  localparam int KX   = GRID_W - 1;
  localparam int KY   = GRID_H - 1;
  localparam int HW   = (GRID_W + 1) / 2;
  localparam int HH   = (GRID_H + 1) / 2;
  localparam int BD   = HW * HH;
  localparam int AW   = (BD > 1) ? $clog2(BD) : 1;
  localparam int MV_N = 8;

  logic [SIZE_W-1:0] in_width, in_height, out_width, out_height;
  logic [SIZE_W-1:0] ow_eff, oh_eff;
  logic [NW-1:0]     lim_x, lim_y;
  logic              adv;

  assign ow_eff = (out_width == '0) ? SIZE_W'(1) : out_width;
  assign oh_eff = (out_height == '0) ? SIZE_W'(1) : out_height;
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= SIZE_W'(640);
      in_height  <= SIZE_W'(480);
      out_width  <= SIZE_W'(640);
      out_height <= SIZE_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IN_WIDTH:   in_width   <= cfg_data;
        REG_IN_HEIGHT:  in_height  <= cfg_data;
        REG_OUT_WIDTH:  out_width  <= cfg_data;
        REG_OUT_HEIGHT: out_height <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_x <= NW'(KX * ow_eff);
    lim_y <= NW'(KY * oh_eff);
  end

  // input capture with v flip
  side_t             in_side, side1, side2;
  logic [SIZE_W-1:0] in_u, in_v, vf_c, u1, vf1;
  logic              v1, v2;
  logic [NW-1:0]     nu2, nv2;

  assign in_side.op  = op_t'(s_axis_tuser[0]);
  assign in_side.col = s_axis_tdata[5:0];
  assign in_side.row = s_axis_tdata[11:6];
  assign in_side.nx  = s_axis_tdata[31:12];
  assign in_side.ny  = s_axis_tdata[51:32];
  assign in_u = s_axis_tdata[65:52];
  assign in_v = s_axis_tdata[79:66];
  assign vf_c = (in_v > out_height) ? '0 : out_height - in_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side1 <= in_side;
      u1    <= in_u;
      vf1   <= vf_c;
      side2 <= side1;
      nu2   <= NW'(u1 * KX);
      nv2   <= NW'(vf1 * KY);
    end
  end

  // restoring divide of pos*k*65536 by size, one quotient bit per stage
  logic              dvv  [0:QB];
  side_t             dside[0:QB];
  logic [SIZE_W-1:0] drx  [0:QB];
  logic [SIZE_W-1:0] dry  [0:QB];
  logic [QB-1:0]     dqx  [0:QB];
  logic [QB-1:0]     dqy  [0:QB];
  logic              dclx [0:QB];
  logic              dcly [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside[0] <= side2;
      drx[0]   <= nu2[NW-1:CB];
      dry[0]   <= nv2[NW-1:CB];
      dqx[0]   <= {nu2[CB-1:0], {FRAC_W{1'b0}}};
      dqy[0]   <= {nv2[CB-1:0], {FRAC_W{1'b0}}};
      dclx[0]  <= (nu2 >= lim_x);
      dcly[0]  <= (nv2 >= lim_y);
    end
  end

  for (genvar i = 0; i < QB; i++) begin : g_div
    logic [SIZE_W:0] tx, ty;
    logic            gx, gy;

    assign tx = {drx[i], dqx[i][QB-1]};
    assign ty = {dry[i], dqy[i][QB-1]};
    assign gx = (tx >= {1'b0, ow_eff});
    assign gy = (ty >= {1'b0, oh_eff});

    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[i+1] <= 1'b0;
      end else if (adv) begin
        dvv[i+1] <= dvv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dside[i+1] <= dside[i];
        drx[i+1]   <= gx ? SIZE_W'(tx - {1'b0, ow_eff}) : tx[SIZE_W-1:0];
        dry[i+1]   <= gy ? SIZE_W'(ty - {1'b0, oh_eff}) : ty[SIZE_W-1:0];
        dqx[i+1]   <= {dqx[i][QB-2:0], gx};
        dqy[i+1]   <= {dqy[i][QB-2:0], gy};
        dclx[i+1]  <= dclx[i];
        dcly[i+1]  <= dcly[i];
      end
    end
  end

  // cell, neighbor and fraction
  logic [CB-1:0]     cx_c, cy_c;
  logic [FRAC_W-1:0] fu_c, fv_c;
  logic              va;
  side_t             sidea;
  logic [CB-1:0]     c0a, c1a, r0a, r1a;
  logic [FRAC_W-1:0] fua, fva;

  assign cx_c = dclx[QB] ? CB'(KX) : dqx[QB][QB-1:FRAC_W];
  assign cy_c = dcly[QB] ? CB'(KY) : dqy[QB][QB-1:FRAC_W];
  assign fu_c = dclx[QB] ? '0 : dqx[QB][FRAC_W-1:0];
  assign fv_c = dcly[QB] ? '0 : dqy[QB][FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= dvv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sidea <= dside[QB];
      c0a   <= cx_c;
      r0a   <= cy_c;
      c1a   <= (cx_c == CB'(KX)) ? cx_c : CB'(cx_c + 1'b1);
      r1a   <= (cy_c == CB'(KY)) ? cy_c : CB'(cy_c + 1'b1);
      fua   <= fu_c;
      fva   <= fv_c;
    end
  end

  // grid banks, loads written in the same stage as map reads
  logic [IDX_W-1:0] ld_col, ld_row;
  logic             ld_ok;
  logic [1:0]       ld_bank;
  logic [AW-1:0]    ld_addr;
  logic [39:0]      rd [0:3];

  assign ld_col  = IDX_W'(sidea.col);
  assign ld_row  = IDX_W'(sidea.row);
  assign ld_ok   = (32'(ld_col) < GRID_W) && (32'(ld_row) < GRID_H);
  assign ld_bank = {ld_row[0], ld_col[0]};
  assign ld_addr = AW'(32'(ld_row >> 1) * HW + 32'(ld_col >> 1));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [CB-1:0] ci, ri;
    logic [AW-1:0] raddr;
    logic          we;

    assign ci    = (c0a[0] == b[0]) ? c0a : c1a;
    assign ri    = (r0a[0] == b[1]) ? r0a : r1a;
    assign raddr = AW'(32'(IDX_W'(ri) >> 1) * HW + 32'(IDX_W'(ci) >> 1));
    assign we    = adv && va && (sidea.op == OP_LOAD) && ld_ok && (ld_bank == 2'(b));

    mlw_ram #(
      .WIDTH (40),
      .DEPTH (BD),
      .ADDR_W(AW)
    ) u_ram (
      .clk  (clk),
      .we   (we),
      .waddr(ld_addr),
      .wdata({sidea.ny, sidea.nx}),
      .re   (adv),
      .raddr(raddr),
      .rdata(rd[b])
    );
  end

  logic              vr;
  op_t               opr;
  logic              sc0, sc1, sr0, sr1;
  logic [FRAC_W-1:0] fur, fvr;
  logic [39:0]       qa, qb, qc, qd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (adv) begin
      vr <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      opr <= sidea.op;
      sc0 <= c0a[0];
      sc1 <= c1a[0];
      sr0 <= r0a[0];
      sr1 <= r1a[0];
      fur <= fua;
      fvr <= fva;
    end
  end

  assign qa = rd[{sr0, sc0}];
  assign qb = rd[{sr0, sc1}];
  assign qc = rd[{sr1, sc0}];
  assign qd = rd[{sr1, sc1}];

  logic signed [NORM_W-1:0] nx_l, ny_l;

  mlw_lerp u_lerp_x (
    .clk(clk), .en(adv),
    .a(qa[19:0]), .b(qb[19:0]), .c(qc[19:0]), .d(qd[19:0]),
    .fu(fur), .fv(fvr), .n(nx_l)
  );

  mlw_lerp u_lerp_y (
    .clk(clk), .en(adv),
    .a(qa[39:20]), .b(qb[39:20]), .c(qc[39:20]), .d(qd[39:20]),
    .fu(fur), .fv(fvr), .n(ny_l)
  );

  // map beat valid through blend and scale
  logic [MV_N-1:0] mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= '0;
    end else if (adv) begin
      mv <= {mv[MV_N-2:0], vr && (opr == OP_MAP)};
    end
  end

  // scale by input size, round, flip y
  logic signed [43:0] mx, my;
  logic signed [27:0] rx_c, ry_c, rx2;
  logic signed [28:0] sy2;

  assign rx_c = 28'((mx + 44'sd32768) >>> 16);
  assign ry_c = 28'((my + 44'sd32768) >>> 16);

  always_ff @(posedge clk) begin
    if (adv) begin
      mx  <= nx_l * $signed({1'b0, in_width});
      my  <= ny_l * $signed({1'b0, in_height});
      rx2 <= rx_c;
      sy2 <= $signed({7'b0, in_height, 8'b0}) - $signed({ry_c[27], ry_c});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= mv[MV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {sat24(sy2), sat24({rx2[27], rx2})};
    end
  end

endmodule
